/* sv/wst_pkg.sv */
// Shared types and codes for the weighted sum-tree sampler.
// No dependencies; the sequencer, datapath, top level and bench refer to it by scoped names.
package wst_pkg;

  localparam int SLOT_BITS    = 8;
  localparam int WEIGHT_BITS  = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int RANDOM_BITS  = 31;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_PICK  = 2'd3
  } op_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic [1:0]              operation;
    logic [SLOT_BITS-1:0]    slot;
    logic [WEIGHT_BITS-1:0]  weight;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [RANDOM_BITS-1:0]  random_value;
  } req_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]    result_slot;
    logic [PAYLOAD_BITS-1:0] result_payload;
    logic [1:0]              status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_POP, S_WRITE, S_CHR, S_CHSUM, S_UPRD, S_UPWR,
    S_TOTAL, S_MUL, S_DL, S_DLC, S_DRC
  } state_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LATCH, CMD_POP, CMD_POP_TAKE, CMD_NEW, CMD_SEL_SLOT,
    CMD_WRITE, CMD_CH_R, CMD_CH_SUM, CMD_UP_RD, CMD_UP_WR, CMD_TOTAL,
    CMD_TOTAL_CHK, CMD_MUL, CMD_DESC_L, CMD_GO_LEFT, CMD_GO_RIGHT_CHK,
    CMD_GO_RIGHT, CMD_PICK, CMD_FIN_OK, CMD_FIN_FULL, CMD_FIN_EMPTY, CMD_FIN_BAD
  } cmd_e;

  typedef struct packed {
    op_e  op;
    logic w_zero;
    logic slot_bad;
    logic has_free;
    logic full;
    logic total_zero;
    logic below;
    logic at_root;
  } dp_stat_t;

endpackage

/* sv/wst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/wst_ctrl.sv */
// Sequencer for the sum-tree sampler: decodes a request and steps the datapath.
// Depends on wst_pkg.
module wst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  wst_pkg::dp_stat_t stat_i,
  output wst_pkg::cmd_e     cmd_o,
  output logic              busy_o
);

  wst_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wst_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and command
  always_comb begin
    state_d = state_q;
    cmd_o   = wst_pkg::CMD_NONE;
    case (state_q)
      wst_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o   = wst_pkg::CMD_LATCH;
          state_d = wst_pkg::S_DECODE;
        end
      end
      wst_pkg::S_DECODE: begin
        case (stat_i.op)
          wst_pkg::OP_ADD: begin
            if (stat_i.w_zero) begin
              cmd_o   = wst_pkg::CMD_FIN_BAD;
              state_d = wst_pkg::S_IDLE;
            end else if (stat_i.has_free) begin
              cmd_o   = wst_pkg::CMD_POP;
              state_d = wst_pkg::S_POP;
            end else if (stat_i.full) begin
              cmd_o   = wst_pkg::CMD_FIN_FULL;
              state_d = wst_pkg::S_IDLE;
            end else begin
              cmd_o   = wst_pkg::CMD_NEW;
              state_d = wst_pkg::S_WRITE;
            end
          end
          wst_pkg::OP_SET: begin
            if (stat_i.slot_bad || stat_i.w_zero) begin
              cmd_o   = wst_pkg::CMD_FIN_BAD;
              state_d = wst_pkg::S_IDLE;
            end else begin
              cmd_o   = wst_pkg::CMD_SEL_SLOT;
              state_d = wst_pkg::S_WRITE;
            end
          end
          wst_pkg::OP_CLEAR: begin
            if (stat_i.slot_bad) begin
              cmd_o   = wst_pkg::CMD_FIN_BAD;
              state_d = wst_pkg::S_IDLE;
            end else begin
              cmd_o   = wst_pkg::CMD_SEL_SLOT;
              state_d = wst_pkg::S_WRITE;
            end
          end
          default: begin
            cmd_o   = wst_pkg::CMD_TOTAL;
            state_d = wst_pkg::S_TOTAL;
          end
        endcase
      end
      wst_pkg::S_POP: begin
        cmd_o   = wst_pkg::CMD_POP_TAKE;
        state_d = wst_pkg::S_WRITE;
      end
      wst_pkg::S_WRITE: begin
        cmd_o   = wst_pkg::CMD_WRITE;
        state_d = wst_pkg::S_CHR;
      end
      wst_pkg::S_CHR: begin
        cmd_o   = wst_pkg::CMD_CH_R;
        state_d = wst_pkg::S_CHSUM;
      end
      wst_pkg::S_CHSUM: begin
        cmd_o   = wst_pkg::CMD_CH_SUM;
        state_d = wst_pkg::S_UPRD;
      end
      wst_pkg::S_UPRD: begin
        if (stat_i.at_root) begin
          cmd_o   = wst_pkg::CMD_FIN_OK;
          state_d = wst_pkg::S_IDLE;
        end else begin
          cmd_o   = wst_pkg::CMD_UP_RD;
          state_d = wst_pkg::S_UPWR;
        end
      end
      wst_pkg::S_UPWR: begin
        cmd_o   = wst_pkg::CMD_UP_WR;
        state_d = wst_pkg::S_UPRD;
      end
      wst_pkg::S_TOTAL: begin
        if (stat_i.total_zero) begin
          cmd_o   = wst_pkg::CMD_FIN_EMPTY;
          state_d = wst_pkg::S_IDLE;
        end else begin
          cmd_o   = wst_pkg::CMD_TOTAL_CHK;
          state_d = wst_pkg::S_MUL;
        end
      end
      wst_pkg::S_MUL: begin
        cmd_o   = wst_pkg::CMD_MUL;
        state_d = wst_pkg::S_DL;
      end
      wst_pkg::S_DL: begin
        cmd_o   = wst_pkg::CMD_DESC_L;
        state_d = wst_pkg::S_DLC;
      end
      wst_pkg::S_DLC: begin
        if (stat_i.below) begin
          cmd_o   = wst_pkg::CMD_GO_LEFT;
          state_d = wst_pkg::S_DL;
        end else begin
          cmd_o   = wst_pkg::CMD_GO_RIGHT_CHK;
          state_d = wst_pkg::S_DRC;
        end
      end
      wst_pkg::S_DRC: begin
        if (stat_i.below) begin
          cmd_o   = wst_pkg::CMD_GO_RIGHT;
          state_d = wst_pkg::S_DL;
        end else begin
          cmd_o   = wst_pkg::CMD_PICK;
          state_d = wst_pkg::S_WRITE;
        end
      end
      default: begin
        state_d = wst_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != wst_pkg::S_IDLE);

endmodule

/* sv/wst_dp.sv */
// Datapath of the sum-tree sampler: tree sums, weights, payloads, free stack.
// Depends on wst_pkg and wst_ram.
module wst_dp #(
  parameter int CAPACITY = 255,
  localparam int NW = $clog2(CAPACITY + 1),
  localparam int CW = NW + 1,
  localparam int SW = wst_pkg::WEIGHT_BITS + NW,
  localparam int PW = SW + wst_pkg::RANDOM_BITS,
  localparam int KW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int XW = (NW > wst_pkg::SLOT_BITS) ? NW : wst_pkg::SLOT_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wst_pkg::cmd_e     cmd_i,
  input  wst_pkg::req_t     req_i,
  output wst_pkg::dp_stat_t stat_o,
  output logic              done_o,
  output wst_pkg::rsp_t     rsp_o
);

  localparam logic [NW-1:0] CAP_N = NW'(CAPACITY);
  localparam logic [NW-1:0] ROOT  = NW'(1);

  wst_pkg::req_t  req_q;
  wst_pkg::rsp_t  rsp_q;
  wst_pkg::op_e   op;
  logic [NW-1:0]  used_q, free_q, node_q;
  logic [wst_pkg::WEIGHT_BITS-1:0] own_q, new_w;
  logic [SW-1:0]  lsum_q, carry_q, total_q, target_q;
  logic           sum_ok_q, done_q;

  logic [CW-1:0]  sum_ra;
  logic           sum_re, sum_we;
  logic [NW-1:0]  sum_wa;
  logic [SW-1:0]  sum_wd, sum_rd, sum_m;
  logic           own_re, own_we;
  logic [wst_pkg::WEIGHT_BITS-1:0] own_rd;
  logic           pay_re, pay_we;
  logic [wst_pkg::PAYLOAD_BITS-1:0] pay_rd;
  logic           stk_re, stk_we;
  logic [KW-1:0]  stk_ra;
  logic [NW-1:0]  stk_rd;
  logic [PW-1:0]  prod;

  assign op    = wst_pkg::op_e'(req_q.operation);
  assign new_w = (op == wst_pkg::OP_ADD || op == wst_pkg::OP_SET) ? req_q.weight : '0;
  // entries above the fill count were never written and read as zero
  assign sum_m = sum_ok_q ? sum_rd : '0;
  assign prod  = PW'(total_q) * PW'(req_q.random_value);

  // sum memory read address
  always_comb begin
    sum_re = 1'b1;
    case (cmd_i)
      wst_pkg::CMD_TOTAL:                      sum_ra = CW'(1);
      wst_pkg::CMD_WRITE, wst_pkg::CMD_DESC_L: sum_ra = {node_q, 1'b0};
      wst_pkg::CMD_CH_R, wst_pkg::CMD_GO_RIGHT_CHK: sum_ra = {node_q, 1'b1};
      wst_pkg::CMD_UP_RD:                      sum_ra = {1'b0, node_q ^ ROOT};
      default: begin
        sum_ra = '0;
        sum_re = 1'b0;
      end
    endcase
  end

  // sum memory write: a node from its own weight and both children
  always_comb begin
    sum_we = 1'b0;
    sum_wa = node_q;
    sum_wd = SW'(own_q) + lsum_q + sum_m;
    case (cmd_i)
      wst_pkg::CMD_CH_SUM: sum_we = 1'b1;
      wst_pkg::CMD_UP_WR: begin
        sum_we = 1'b1;
        sum_wa = node_q >> 1;
        sum_wd = SW'(own_rd) + carry_q + sum_m;
      end
      default: sum_we = 1'b0;
    endcase
  end

  assign own_re = (cmd_i == wst_pkg::CMD_UP_RD);
  assign own_we = (cmd_i == wst_pkg::CMD_WRITE);
  assign pay_re = (cmd_i == wst_pkg::CMD_PICK);
  assign pay_we = (cmd_i == wst_pkg::CMD_WRITE) && (op == wst_pkg::OP_ADD);
  assign stk_re = (cmd_i == wst_pkg::CMD_POP);
  assign stk_we = (cmd_i == wst_pkg::CMD_PICK) && (free_q < CAP_N);
  assign stk_ra = KW'(free_q - NW'(1));

  wst_ram #(.WIDTH(SW), .DEPTH(CAPACITY + 1)) u_sum_ram (
    .clk_i, .we_i(sum_we), .waddr_i(sum_wa), .wdata_i(sum_wd),
    .re_i(sum_re && (sum_ra <= {1'b0, used_q})), .raddr_i(sum_ra[NW-1:0]), .rdata_o(sum_rd)
  );

  wst_ram #(.WIDTH(wst_pkg::WEIGHT_BITS), .DEPTH(CAPACITY + 1)) u_own_ram (
    .clk_i, .we_i(own_we), .waddr_i(node_q), .wdata_i(new_w),
    .re_i(own_re), .raddr_i(node_q >> 1), .rdata_o(own_rd)
  );

  wst_ram #(.WIDTH(wst_pkg::PAYLOAD_BITS), .DEPTH(CAPACITY + 1)) u_pay_ram (
    .clk_i, .we_i(pay_we), .waddr_i(node_q), .wdata_i(req_q.payload),
    .re_i(pay_re), .raddr_i(node_q), .rdata_o(pay_rd)
  );

  wst_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_stk_ram (
    .clk_i, .we_i(stk_we), .waddr_i(KW'(free_q)), .wdata_i(node_q),
    .re_i(stk_re), .raddr_i(stk_ra), .rdata_o(stk_rd)
  );

  // counters, read mask and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      free_q   <= '0;
      sum_ok_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (sum_re) begin
        sum_ok_q <= (sum_ra <= {1'b0, used_q});
      end
      if (cmd_i == wst_pkg::CMD_NEW) begin
        used_q <= used_q + NW'(1);
      end
      if (cmd_i == wst_pkg::CMD_POP) begin
        free_q <= free_q - NW'(1);
      end else if (stk_we) begin
        free_q <= free_q + NW'(1);
      end
      done_q <= (cmd_i == wst_pkg::CMD_FIN_OK) || (cmd_i == wst_pkg::CMD_FIN_FULL) ||
                (cmd_i == wst_pkg::CMD_FIN_EMPTY) || (cmd_i == wst_pkg::CMD_FIN_BAD);
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      wst_pkg::CMD_LATCH: begin
        req_q <= req_i;
        rsp_q <= '0;
      end
      wst_pkg::CMD_POP_TAKE: node_q <= stk_rd;
      wst_pkg::CMD_NEW:      node_q <= used_q + NW'(1);
      wst_pkg::CMD_SEL_SLOT: node_q <= NW'(req_q.slot);
      wst_pkg::CMD_WRITE: begin
        own_q <= new_w;
        rsp_q.result_slot <= (op == wst_pkg::OP_ADD || op == wst_pkg::OP_PICK) ?
                             wst_pkg::SLOT_BITS'(node_q) : '0;
        rsp_q.result_payload <= (op == wst_pkg::OP_PICK) ? pay_rd : '0;
      end
      wst_pkg::CMD_CH_R:   lsum_q <= sum_m;
      wst_pkg::CMD_CH_SUM: carry_q <= sum_wd;
      wst_pkg::CMD_UP_WR: begin
        carry_q <= sum_wd;
        node_q  <= node_q >> 1;
      end
      wst_pkg::CMD_TOTAL_CHK: total_q <= sum_m;
      wst_pkg::CMD_MUL: begin
        target_q <= SW'(prod >> wst_pkg::RANDOM_BITS);
        node_q   <= ROOT;
      end
      wst_pkg::CMD_GO_LEFT:      node_q <= {node_q[NW-2:0], 1'b0};
      wst_pkg::CMD_GO_RIGHT_CHK: target_q <= target_q - sum_m;
      wst_pkg::CMD_GO_RIGHT:     node_q <= {node_q[NW-2:0], 1'b1};
      wst_pkg::CMD_FIN_OK:       rsp_q.status <= wst_pkg::ST_OK;
      wst_pkg::CMD_FIN_FULL:     rsp_q.status <= wst_pkg::ST_FULL;
      wst_pkg::CMD_FIN_EMPTY:    rsp_q.status <= wst_pkg::ST_EMPTY;
      wst_pkg::CMD_FIN_BAD:      rsp_q.status <= wst_pkg::ST_BAD;
      default: ;
    endcase
  end

  // status toward the sequencer
  always_comb begin
    stat_o.op         = op;
    stat_o.w_zero     = (req_q.weight == '0);
    stat_o.slot_bad   = (req_q.slot == '0) || (XW'(req_q.slot) > XW'(used_q));
    stat_o.has_free   = (free_q != '0);
    stat_o.full       = (used_q == CAP_N);
    stat_o.total_zero = (sum_m == '0);
    stat_o.below      = (target_q < sum_m);
    stat_o.at_root    = (node_q == ROOT);
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_used_cap: assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= CAP_N)
    else $error("used count above capacity");
  a_free_cap: assert property (@(posedge clk_i) disable iff (!rst_ni) free_q <= CAP_N)
    else $error("free count above capacity");
  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |=> !done_q)
    else $error("result strobe longer than one cycle");
  a_node_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == wst_pkg::CMD_WRITE |-> node_q != '0 && node_q <= used_q)
    else $error("write to a slot outside the live range");

endmodule

/* sv/weighted_sum_tree_sampler.sv */
// Top level of the weighted sum-tree sampler: sequencer plus datapath.
// Depends on wst_pkg, wst_ctrl, wst_dp (and wst_ram below it).
//
//  channel   | signals            | direction | taken when
//  ----------+--------------------+-----------+----------------------------
//  request   | start, req_i       | in        | start high, busy low
//  status    | busy               | out       | -
//  result    | done_o, rsp_o      | out       | done_o high, one cycle only
//
// An add, set or clear writes the slot's own weight, forms its sum from that
// weight and both children, then walks up to the root rewriting each ancestor's
// sum; an add may first take its slot off the free stack. A pick descends from
// the root (depth 0) to the chosen slot, at most log2(CAPACITY+1)-1 levels down,
// and then clears it the same way. A rejected request or a pick on an empty
// tree finishes without touching the tree. The single read port of the sum
// memory sets the pace: a read and a write per level up, up to two reads down.
// Reset clears the counters; no memory clearing pass is needed, entries above
// the fill count read as zero. The receiver cannot stall; a new request may
// be taken in the cycle its predecessor's result is shown.
module weighted_sum_tree_sampler #(
  parameter int CAPACITY = 255
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  wst_pkg::req_t req_i,
  output logic          done_o,
  output wst_pkg::rsp_t rsp_o
);

  wst_pkg::cmd_e     cmd;
  wst_pkg::dp_stat_t stat;

  wst_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .stat_i(stat), .cmd_o(cmd), .busy_o(busy)
  );

  wst_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i, .stat_o(stat), .done_o, .rsp_o
  );

endmodule

/* sim/weighted_sum_tree_sampler_tb.sv */
// Self-checking bench for the weighted sum-tree sampler: random and directed
// add/set/clear/pick requests against an in-bench tree model. Needs wst_pkg.
`timescale 1ns / 100ps

module weighted_sum_tree_sampler_tb;

  localparam int CAP = 255;
  localparam int NODES = 2 * CAP + 2;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  wst_pkg::req_t req_i = '0;
  logic done_o;
  wst_pkg::rsp_t rsp_o;

  weighted_sum_tree_sampler #(.CAPACITY(CAP)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Tree model state
  logic [15:0] own_w [CAP+1];
  logic [31:0] sums [NODES];
  logic [31:0] pay_mem [CAP+1];
  logic [7:0]  free_slots [CAP];
  int unsigned n_free, n_used;

  wst_pkg::req_t pending_reqs[$];
  wst_pkg::rsp_t expected_rsps[$];
  int errors = 0;
  int n_sent = 0, n_rcvd = 0, n_picks = 0, n_full = 0, n_empty = 0;
  bit gaps_on = 1'b1;
  bit stim_done = 1'b0;

  function automatic void resum_path(int unsigned node);
    while (node > 0) begin
      sums[node] = 32'(own_w[node]) + sums[2*node] + sums[2*node+1];
      node = node >> 1;
    end
  endfunction

  // Compute the response of one request and advance the model
  function automatic wst_pkg::rsp_t sampler_step(wst_pkg::req_t r);
    wst_pkg::rsp_t o;
    int unsigned hi, li;
    logic [63:0] target;
    o = '0;
    case (wst_pkg::op_e'(r.operation))
      wst_pkg::OP_ADD: begin
        if (r.weight == 0) o.status = wst_pkg::ST_BAD;
        else if (n_free > 0) begin
          n_free--;
          hi = 32'(free_slots[n_free]);
          pay_mem[hi] = r.payload; own_w[hi] = r.weight;
          resum_path(hi);
          o.result_slot = hi[7:0];
        end else if (n_used >= CAP) o.status = wst_pkg::ST_FULL;
        else begin
          n_used++;
          hi = n_used;
          sums[2*hi] = '0; sums[2*hi+1] = '0;
          pay_mem[hi] = r.payload; own_w[hi] = r.weight;
          resum_path(hi);
          o.result_slot = hi[7:0];
        end
      end
      wst_pkg::OP_SET, wst_pkg::OP_CLEAR: begin
        if (r.slot == 0 || 32'(r.slot) > n_used ||
            (r.operation == wst_pkg::OP_SET && r.weight == 0))
          o.status = wst_pkg::ST_BAD;
        else begin
          own_w[r.slot] = (r.operation == wst_pkg::OP_SET) ? r.weight : 16'd0;
          resum_path(32'(r.slot));
        end
      end
      default: begin
        if (sums[1] == 0) o.status = wst_pkg::ST_EMPTY;
        else begin
          target = (64'(sums[1]) * 64'(r.random_value)) >> 31;
          li = 1;
          while (li <= CAP) begin
            if (target < 64'(sums[2*li])) li = 2 * li;
            else begin
              target -= 64'(sums[2*li]);
              if (target < 64'(sums[2*li+1])) li = 2 * li + 1;
              else break;
            end
          end
          if (li > CAP) li = CAP;
          o.result_slot = li[7:0];
          o.result_payload = pay_mem[li];
          if (n_free < CAP) begin
            free_slots[n_free] = li[7:0];
            n_free++;
          end
          own_w[li] = '0;
          resum_path(li);
        end
      end
    endcase
    return o;
  endfunction

  // Driver: present queued requests at the falling edge, with random gaps
  int gap_left = 0;
  logic taken_q = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !taken_q) begin
        // hold current request until it is taken
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        start <= 1'b1;
        req_i <= pending_reqs.pop_front();
        if (gaps_on && $urandom_range(0, 7) == 0) gap_left <= int'($urandom_range(1, 19));
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: accept requests and check responses at the rising edge
  wst_pkg::rsp_t exp_rsp;
  always @(posedge clk_i) begin
    taken_q <= start && !busy;
    if (rst_ni) begin
      if (done_o) begin
        n_rcvd++;
        if (expected_rsps.size() == 0) begin
          $error("response with none expected");
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp_o.result_slot !== exp_rsp.result_slot) begin
            $error("result_slot exp %0d got %0d", exp_rsp.result_slot, rsp_o.result_slot);
            errors++;
          end
          if (rsp_o.result_payload !== exp_rsp.result_payload) begin
            $error("result_payload exp %h got %h", exp_rsp.result_payload,
                   rsp_o.result_payload);
            errors++;
          end
          if (rsp_o.status !== exp_rsp.status) begin
            $error("status exp %0d got %0d", exp_rsp.status, rsp_o.status);
            errors++;
          end
          if (exp_rsp.status == wst_pkg::ST_FULL) n_full++;
          if (exp_rsp.status == wst_pkg::ST_EMPTY) n_empty++;
        end
      end
      if (start && !busy) begin
        n_sent++;
        if (req_i.operation == wst_pkg::OP_PICK) n_picks++;
        expected_rsps.push_back(sampler_step(req_i));
      end
    end
  end

  function automatic wst_pkg::req_t mk_req(wst_pkg::op_e op, logic [7:0] s,
                                           logic [15:0] w);
    wst_pkg::req_t r;
    r.operation = op;
    r.slot = s;
    r.weight = w;
    r.payload = $urandom;
    r.random_value = 31'($urandom);
    return r;
  endfunction

  // Stimulus
  initial begin
    wst_pkg::req_t r;
    int k;
    foreach (own_w[i]) own_w[i] = '0;
    foreach (sums[i]) sums[i] = '0;
    n_free = 0; n_used = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: empty pick, bad slots and weights, extremes
    pending_reqs.push_back(mk_req(wst_pkg::OP_PICK, 8'd0, 16'd0));
    pending_reqs.push_back(mk_req(wst_pkg::OP_ADD, 8'd0, 16'd0));
    pending_reqs.push_back(mk_req(wst_pkg::OP_SET, 8'd1, 16'd5));
    pending_reqs.push_back(mk_req(wst_pkg::OP_CLEAR, 8'd0, 16'd0));
    r = mk_req(wst_pkg::OP_ADD, 8'd0, 16'hFFFF); r.payload = '1; pending_reqs.push_back(r);
    r = mk_req(wst_pkg::OP_ADD, 8'd255, 16'd1); r.payload = '0; pending_reqs.push_back(r);
    pending_reqs.push_back(mk_req(wst_pkg::OP_SET, 8'd1, 16'd0));
    pending_reqs.push_back(mk_req(wst_pkg::OP_SET, 8'd255, 16'd3));
    pending_reqs.push_back(mk_req(wst_pkg::OP_SET, 8'd2, 16'hFFFF));
    r = mk_req(wst_pkg::OP_PICK, 8'd0, 16'd0); r.random_value = '1; pending_reqs.push_back(r);
    r = mk_req(wst_pkg::OP_PICK, 8'd0, 16'd0); r.random_value = '0; pending_reqs.push_back(r);
    pending_reqs.push_back(mk_req(wst_pkg::OP_PICK, 8'd0, 16'd0));
    pending_reqs.push_back(mk_req(wst_pkg::OP_SET, 8'd1, 16'd9));   // set on a freed slot
    pending_reqs.push_back(mk_req(wst_pkg::OP_CLEAR, 8'd1, 16'd0));
    pending_reqs.push_back(mk_req(wst_pkg::OP_PICK, 8'd0, 16'd0));

    // Fill the tree to capacity, then overflow
    for (k = 0; k < 260; k++)
      pending_reqs.push_back(mk_req(wst_pkg::OP_ADD, 8'($urandom),
                                    16'($urandom_range(1, 65535))));
    // Picks until the free stack is full, with some pushes dropped
    for (k = 0; k < 270; k++) begin
      r = mk_req(wst_pkg::OP_PICK, 8'd0, 16'd0);
      if (k % 5 == 0)
        pending_reqs.push_back(mk_req(wst_pkg::OP_SET, 8'($urandom_range(1, 255)),
                                      16'($urandom_range(1, 65535))));
      pending_reqs.push_back(r);
    end

    // Random mix, the last part without gaps
    for (k = 0; k < 100; k++) begin
      if (k == 70) begin
        wait (pending_reqs.size() == 0);
        gaps_on = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: pending_reqs.push_back(mk_req(wst_pkg::OP_ADD, 8'($urandom),
                                         ($urandom_range(0, 15) == 0) ? 16'd0 :
                                                                        16'($urandom)));
        1: pending_reqs.push_back(mk_req(wst_pkg::OP_SET, 8'($urandom), 16'($urandom)));
        2: pending_reqs.push_back(mk_req(wst_pkg::OP_CLEAR, 8'($urandom), 16'($urandom)));
        default: pending_reqs.push_back(mk_req(wst_pkg::OP_PICK, 8'($urandom),
                                               16'($urandom)));
      endcase
    end

    wait (pending_reqs.size() == 0 && !start);
    wait (expected_rsps.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("%0d requests sent, %0d responses, %0d picks, %0d full, %0d empty",
             n_sent, n_rcvd, n_picks, n_full, n_empty);
    if (errors == 0 && expected_rsps.size() == 0)
      $display("weighted_sum_tree_sampler: match");
    else
      $display("weighted_sum_tree_sampler: mismatch");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("weighted_sum_tree_sampler: mismatch");
    $finish;
  end

endmodule

/* sim.f */
sv/wst_pkg.sv
sv/wst_ram.sv
sv/wst_ctrl.sv
sv/wst_dp.sv
sv/weighted_sum_tree_sampler.sv
sim/weighted_sum_tree_sampler_tb.sv
